>>> rtl/core/tlrd_pkg.sv
package tlrd_pkg;

    localparam int LINE_DEPTH_DEF = 10;
    localparam int MAX_RESULTS    = 9;
    localparam int TAG_COUNT      = 10;

    localparam int CHAR_W = 8;
    localparam int SLOT_W = 4;
    localparam int POS_W  = 4;
    localparam int REG_W  = 1;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [REG_W-1:0]  t_reg_idx;

    localparam t_reg_idx REG_LINE_END  = 1'd0;
    localparam t_reg_idx REG_FIRST_TAG = 1'd1;

    localparam t_char LINE_END_RST  = 8'h0D;
    localparam t_char FIRST_TAG_RST = 8'h41;

endpackage

>>> rtl/core/tagged_line_record_deframer_unit.sv
// A data byte is taken at 1 request per cycle while the unit is idle; a line end with a known tag
// stalls the input and starts the record scan, which reads the buffer through its single
// read port into a register (S_READ) and then issues one result from it (S_LOAD) before
// the next byte is read; an empty payload goes straight to the terminator (S_TERM).
// An output stall holds the scan.
// Reset: synchronous active low; clears the write index and control, and restores the config registers to defaults.
module tagged_line_record_deframer_unit #(
    parameter int LINE_DEPTH = tlrd_pkg::LINE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  tlrd_pkg::t_reg_idx i_cfg_index,
    input  tlrd_pkg::t_char   i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  tlrd_pkg::t_char   i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output tlrd_pkg::t_slot   o_slot,
    output tlrd_pkg::t_pos    o_position,
    output tlrd_pkg::t_char   o_payload_char,
    output logic              o_last
);
    import tlrd_pkg::*;

    localparam int AW = $clog2(LINE_DEPTH);
    localparam logic [AW-1:0] LastIdx = AW'(LINE_DEPTH - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;
    localparam logic [1:0] S_TERM = 2'd3;

    t_char           r_mem [LINE_DEPTH];
    t_char           r_rd_data;
    logic [1:0]      r_state, n_state;
    logic [AW-1:0]   r_wr_idx, n_wr_idx;
    logic [AW-1:0]   r_len, n_len;
    logic [AW-1:0]   r_rd_idx, n_rd_idx;
    t_pos            r_n, n_n;
    t_char           r_tag, n_tag;
    t_char           r_line_end, r_first_tag;
    t_slot           r_slot, n_slot;
    logic            r_o_valid, n_o_valid;
    t_slot           r_o_slot, n_o_slot;
    t_pos            r_o_pos, n_o_pos;
    t_char           r_o_char, n_o_char;
    logic            r_o_last, n_o_last;

    logic            in_acc;
    logic            out_free;
    logic            mem_we;
    t_char           tag_byte;
    t_char           slot_full;
    logic [AW:0]     next_idx;

    assign o_cfg_ready    = 1'b1;
    assign o_in_stall     = (r_state != S_IDLE);
    assign in_acc         = i_in_valid && !o_in_stall;
    assign out_free       = !r_o_valid || !i_out_stall;
    assign mem_we         = in_acc && (i_rx_byte != r_line_end);
    assign tag_byte       = (r_wr_idx == '0) ? '0 : r_tag;
    assign slot_full      = tag_byte - r_first_tag;
    assign next_idx       = {1'b0, r_rd_idx} + 1'b1;

    assign o_out_valid    = r_o_valid;
    assign o_slot         = r_o_slot;
    assign o_position     = r_o_pos;
    assign o_payload_char = r_o_char;
    assign o_last         = r_o_last;

    always_comb begin
        n_state   = r_state;
        n_wr_idx  = r_wr_idx;
        n_len     = r_len;
        n_rd_idx  = r_rd_idx;
        n_n       = r_n;
        n_tag     = r_tag;
        n_slot    = r_slot;
        n_o_valid = r_o_valid && i_out_stall;
        n_o_slot  = r_o_slot;
        n_o_pos   = r_o_pos;
        n_o_char  = r_o_char;
        n_o_last  = r_o_last;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_rx_byte != r_line_end) begin
                        if (r_wr_idx == '0) begin
                            n_tag = i_rx_byte;
                        end
                        n_wr_idx = (r_wr_idx == LastIdx) ? '0 : r_wr_idx + 1'b1;
                    end else begin
                        n_wr_idx = '0;
                        n_len    = r_wr_idx;
                        n_rd_idx = AW'(1);
                        n_n      = '0;
                        n_slot   = slot_full[SLOT_W-1:0];
                        if (slot_full < CHAR_W'(TAG_COUNT)) begin
                            n_state = (r_wr_idx > AW'(1)) ? S_READ : S_TERM;
                        end
                    end
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_slot  = r_slot;
                    n_o_pos   = r_n;
                    if (r_rd_data == '0) begin
                        n_o_char = '0;
                        n_o_last = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_o_char = r_rd_data;
                        n_o_last = 1'b0;
                        n_n      = r_n + 1'b1;
                        n_rd_idx = next_idx[AW-1:0];
                        if (next_idx < {1'b0, r_len} && r_n < POS_W'(MAX_RESULTS - 2)) begin
                            n_state = S_READ;
                        end else begin
                            n_state = S_TERM;
                        end
                    end
                end
            end
            S_TERM: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_slot  = r_slot;
                    n_o_pos   = r_n;
                    n_o_char  = '0;
                    n_o_last  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wr_idx] <= i_rx_byte;
        end
        if (r_state == S_READ) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_idx    <= '0;
            r_o_valid   <= 1'b0;
            r_line_end  <= LINE_END_RST;
            r_first_tag <= FIRST_TAG_RST;
        end else begin
            r_state   <= n_state;
            r_wr_idx  <= n_wr_idx;
            r_o_valid <= n_o_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_LINE_END:  r_line_end  <= i_cfg_data;
                    REG_FIRST_TAG: r_first_tag <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_rd_idx <= n_rd_idx;
        r_n      <= n_n;
        r_tag    <= n_tag;
        r_slot   <= n_slot;
        r_o_slot <= n_o_slot;
        r_o_pos  <= n_o_pos;
        r_o_char <= n_o_char;
        r_o_last <= n_o_last;
    end

endmodule

>>> rtl/core/tlrd_checker.sv
module tlrd_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input tlrd_pkg::t_slot   o_slot,
    input tlrd_pkg::t_pos    o_position,
    input tlrd_pkg::t_char   o_payload_char,
    input logic              o_last
);
    import tlrd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_payload_char)
            && $stable(o_last) && $stable(o_position))
        else $error("stalled request changed");

    a_term_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_payload_char == '0)
        else $error("terminator carries data");

    a_data_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_payload_char != '0
            && o_position < POS_W'(MAX_RESULTS - 1))
        else $error("bad payload request");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_slot < SLOT_W'(TAG_COUNT) && o_position < POS_W'(MAX_RESULTS))
        else $error("slot or position out of range");

endmodule

bind tagged_line_record_deframer_unit tlrd_checker u_tlrd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_slot         (o_slot),
    .o_position     (o_position),
    .o_payload_char (o_payload_char),
    .o_last         (o_last)
);
